### rtl/ultrasonic_ranging_obstacle_steer_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ULTRASONIC_RANGING_OBSTACLE_STEER_MACROS_SVH
`define ULTRASONIC_RANGING_OBSTACLE_STEER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define UROS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uros assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define UROS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uros assertion failed");

// The consequent must hold in the cycle after the antecedent, checked during reset too.
`define UROS_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("uros assertion failed");

`endif

### rtl/uros_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uros_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int SENSOR_W     = 2;
  localparam int DIST_W       = 17;
  localparam int TIMER_W      = 32;
  localparam int SCALE_W      = 24;
  localparam int SCALE_FRAC   = 24;
  localparam int PROD_W       = TIMER_W + SCALE_W;
  localparam int CODE_W       = 8;
  localparam int ACTION_W     = 2;
  localparam int DRIVE_W      = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 24;

  localparam logic [DIST_W-1:0]  DIST_MAX        = 17'h1FFFF;
  localparam logic [DIST_W-1:0]  DIST_RESET      = 17'd6400;
  localparam logic [DIST_W-1:0]  CLEARANCE_RESET = 17'd1600;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 24'd1140851;
  localparam logic [CODE_W-1:0]  LEFT_RESET      = 8'd76;
  localparam logic [CODE_W-1:0]  RIGHT_RESET     = 8'd82;

  localparam logic [ACTION_W-1:0] ACT_ECHO    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COMMAND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CLEARANCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT     = 2'd3;

  typedef enum logic [DRIVE_W-1:0] {
    DRIVE_STOP     = 3'd0,
    DRIVE_FORWARD  = 3'd1,
    DRIVE_BACKWARD = 3'd2,
    DRIVE_LEFT     = 3'd3,
    DRIVE_RIGHT    = 3'd4
  } drive_t;

  typedef enum logic [1:0] {
    STEER_MIDDLE = 2'd0,
    STEER_LEFT   = 2'd1,
    STEER_RIGHT  = 2'd2
  } steer_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                level;
    steer_t              steer;
  } stage_ctrl_t;

  function automatic drive_t pick_drive(input logic [SENSOR_COUNT-1:0] clear,
                                        input steer_t steer);
    drive_t result;
    if (clear[0] && clear[1] && clear[2]) begin
      if (steer == STEER_LEFT) begin
        result = DRIVE_LEFT;
      end else if (steer == STEER_RIGHT) begin
        result = DRIVE_RIGHT;
      end else begin
        result = DRIVE_FORWARD;
      end
    end else if (!clear[0] && clear[2]) begin
      result = DRIVE_RIGHT;
    end else if (clear[0] && !clear[2]) begin
      result = DRIVE_LEFT;
    end else if (clear[3]) begin
      result = DRIVE_BACKWARD;
    end else begin
      result = DRIVE_STOP;
    end
    return result;
  endfunction

endpackage

`default_nettype wire

### rtl/ultrasonic_ranging_obstacle_steer.sv
// Serves four ultrasonic sensors in turn and steers a vehicle around obstacles. Each input
// beat is one event: a measurement tick that asks for a trigger on the active sensor, an echo
// edge (a rising edge captures the down-counting timer, a falling edge turns the elapsed count
// into a saturated distance in 1/64 cm, stores it and moves to the next sensor), or a command
// byte that latches a left, right or middle request. Every event yields exactly one result
// beat carrying the motor drive after that event. The block accepts one beat per cycle while
// in_stall is low; out_stall back-pressure can raise it. The edge that takes an input beat
// registers the input and the elapsed count, a second register the 32 by 24 bit scale
// multiply, and the output register the saturation, distance store and drive decision.
// Configuration writes are always ready and take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_ranging_obstacle_steer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [uros_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [uros_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [uros_pkg::ACTION_W-1:0]        action,
  input  logic                                 echo_level,
  input  logic [uros_pkg::TIMER_W-1:0]         timer_value,
  input  logic [uros_pkg::CODE_W-1:0]          command_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [uros_pkg::DRIVE_W-1:0]         drive,
  output logic                                 trigger_start,
  output logic [uros_pkg::SENSOR_W-1:0]        trigger_sensor,
  output logic                                 measured,
  output logic [uros_pkg::SENSOR_W-1:0]        measured_sensor,
  output logic [uros_pkg::DIST_W-1:0]          measured_distance
);

  logic [uros_pkg::DIST_W-1:0]   clearance_threshold;
  logic [uros_pkg::SCALE_W-1:0]  distance_scale;
  logic [uros_pkg::CODE_W-1:0]   left_command_code;
  logic [uros_pkg::CODE_W-1:0]   right_command_code;

  logic [uros_pkg::DIST_W-1:0]   sensor_distances [uros_pkg::SENSOR_COUNT];
  logic [uros_pkg::TIMER_W-1:0]  echo_start_time;
  logic [uros_pkg::SENSOR_W-1:0] active_sensor;
  uros_pkg::steer_t              steer_request;

  logic                          s1_valid;
  uros_pkg::stage_ctrl_t         s1_ctrl;
  logic [uros_pkg::TIMER_W-1:0]  s1_elapsed;
  logic                          s2_valid;
  uros_pkg::stage_ctrl_t         s2_ctrl;
  logic [uros_pkg::PROD_W-1:0]   s2_product;

  logic                          out_ready;
  logic                          s2_ready;
  logic                          s1_ready;
  logic                          in_accept;
  logic                          s1_move;
  logic                          s2_move;

  uros_pkg::steer_t              in_steer;
  logic [uros_pkg::DIST_W-1:0]   s2_distance;
  logic                          s2_store;
  logic [uros_pkg::DIST_W-1:0]   distances_next [uros_pkg::SENSOR_COUNT];
  logic [uros_pkg::SENSOR_COUNT-1:0] clear_next;
  uros_pkg::steer_t              steer_request_next;
  uros_pkg::drive_t              drive_next;
  logic                          trigger_next;

  assign cfg_ready = 1'b1;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;
  assign s1_move   = s1_valid && s2_ready;
  assign s2_move   = s2_valid && out_ready;

  always_comb begin
    priority if (command_byte == left_command_code) begin
      in_steer = uros_pkg::STEER_LEFT;
    end else if (command_byte == right_command_code) begin
      in_steer = uros_pkg::STEER_RIGHT;
    end else begin
      in_steer = uros_pkg::STEER_MIDDLE;
    end
  end

  // The product keeps 24 fraction bits; anything above the distance field saturates.
  always_comb begin
    if (|s2_product[uros_pkg::PROD_W-1:uros_pkg::SCALE_FRAC+uros_pkg::DIST_W]) begin
      s2_distance = uros_pkg::DIST_MAX;
    end else begin
      s2_distance = s2_product[uros_pkg::SCALE_FRAC+uros_pkg::DIST_W-1:uros_pkg::SCALE_FRAC];
    end
    s2_store = (s2_ctrl.action == uros_pkg::ACT_ECHO) && !s2_ctrl.level;
    for (int i = 0; i < uros_pkg::SENSOR_COUNT; i++) begin
      if (s2_store && (active_sensor == uros_pkg::SENSOR_W'(i))) begin
        distances_next[i] = s2_distance;
      end else begin
        distances_next[i] = sensor_distances[i];
      end
      clear_next[i] = distances_next[i] >= clearance_threshold;
    end
    if (s2_ctrl.action == uros_pkg::ACT_COMMAND) begin
      steer_request_next = s2_ctrl.steer;
    end else begin
      steer_request_next = steer_request;
    end
    drive_next   = uros_pkg::pick_drive(clear_next, steer_request_next);
    trigger_next = s2_ctrl.action == uros_pkg::ACT_TICK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearance_threshold <= uros_pkg::CLEARANCE_RESET;
      distance_scale      <= uros_pkg::SCALE_RESET;
      left_command_code   <= uros_pkg::LEFT_RESET;
      right_command_code  <= uros_pkg::RIGHT_RESET;
      for (int i = 0; i < uros_pkg::SENSOR_COUNT; i++) begin
        sensor_distances[i] <= uros_pkg::DIST_RESET;
      end
      echo_start_time <= '0;
      active_sensor   <= '0;
      steer_request   <= uros_pkg::STEER_MIDDLE;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          uros_pkg::CFG_CLEARANCE: begin
            clearance_threshold <= cfg_data[uros_pkg::DIST_W-1:0];
          end
          uros_pkg::CFG_SCALE: begin
            distance_scale <= cfg_data[uros_pkg::SCALE_W-1:0];
          end
          uros_pkg::CFG_LEFT: begin
            left_command_code <= cfg_data[uros_pkg::CODE_W-1:0];
          end
          uros_pkg::CFG_RIGHT: begin
            right_command_code <= cfg_data[uros_pkg::CODE_W-1:0];
          end
        endcase
      end
      if (in_accept && (action == uros_pkg::ACT_ECHO) && echo_level) begin
        echo_start_time <= timer_value;
      end
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
      if (s2_move) begin
        for (int i = 0; i < uros_pkg::SENSOR_COUNT; i++) begin
          sensor_distances[i] <= distances_next[i];
        end
        steer_request <= steer_request_next;
        if (s2_store) begin
          active_sensor <= active_sensor + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctrl.action <= action;
      s1_ctrl.level  <= echo_level;
      s1_ctrl.steer  <= in_steer;
      s1_elapsed     <= echo_start_time - timer_value;
    end
    if (s1_move) begin
      s2_ctrl    <= s1_ctrl;
      s2_product <= uros_pkg::PROD_W'(s1_elapsed) * uros_pkg::PROD_W'(distance_scale);
    end
    if (s2_move) begin
      drive             <= drive_next;
      trigger_start     <= trigger_next;
      trigger_sensor    <= trigger_next ? active_sensor : '0;
      measured          <= s2_store;
      measured_sensor   <= s2_store ? active_sensor : '0;
      measured_distance <= s2_store ? s2_distance : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/uros_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_ranging_obstacle_steer_macros.svh"

module uros_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [uros_pkg::DRIVE_W-1:0]      drive,
  input logic                              trigger_start,
  input logic [uros_pkg::SENSOR_W-1:0]     trigger_sensor,
  input logic                              measured,
  input logic [uros_pkg::SENSOR_W-1:0]     measured_sensor,
  input logic [uros_pkg::DIST_W-1:0]       measured_distance
);

  `UROS_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `UROS_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid)
  `UROS_ASSERT_SAME(a_one_event, clk, rst, out_valid, !(trigger_start && measured))
  `UROS_ASSERT_SAME(a_quiet_fields, clk, rst, out_valid, (trigger_start || trigger_sensor == '0) && (measured || (measured_sensor == '0 && measured_distance == '0)))
  `UROS_ASSERT_SAME(a_drive_code, clk, rst, out_valid, drive <= 3'(uros_pkg::DRIVE_RIGHT))

endmodule

bind ultrasonic_ranging_obstacle_steer uros_checker u_uros_checker (.*);

`default_nettype wire
